FILE: src/pdsr_pkg.sv
// Shared types and constants for the PWM duty controller with soft-start ramp.
// Used by pdsr_div and pwm_duty_soft_start_ramp; depends on nothing else.
package pdsr_pkg;

  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned CMP_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [DUTY_W-1:0] PCT_FULL = 7'd100;

  // Division by one hundred as floor(x * CMP_RECIP / 2**CMP_SHIFT). The result is
  // exact for every x below 2**23, which covers duty * (reload + 1).
  localparam int unsigned        RECIP_W   = 24;
  localparam int unsigned        CMP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] CMP_RECIP = 24'd10737419;

  typedef enum logic [1:0] {
    ACT_SET_SPEED  = 2'd0,
    ACT_STOP       = 2'd1,
    ACT_SOFT_START = 2'd2,
    ACT_TICK       = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TOTAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_RELOAD = 3'd4;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/pdsr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pdsr_pkg for the status struct.
module pdsr_div #(
  parameter int unsigned DIVIDEND_W = 24,
  parameter int unsigned DIVISOR_W  = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [DIVIDEND_W-1:0]  dividend_i,
  input  logic [DIVISOR_W-1:0]   divisor_i,
  output pdsr_pkg::div_stat_t    stat_o,
  output logic [DIVIDEND_W-1:0]  quotient_o
);
  import pdsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d, div_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    rem_sh, rem_diff;
  logic                  ge;

  always_comb begin
    rem_sh   = {rem_q, quo_q[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, div_q};
    ge       = (rem_sh >= {1'b0, div_q});
    rem_d    = ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    quo_d    = {quo_q[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

FILE: src/pwm_duty_soft_start_ramp.sv
// Top level of the motor PWM duty controller with soft-start ramp.
// Depends on pdsr_pkg and on the divider pdsr_div.
//
//   Channel   Direction  Signals                      Contents
//   s_axis    in         tvalid tready tdata tuser    one command or 1 ms tick
//   m_axis    out        tvalid tready tdata          status, duty, compare, ramp flag
//   cfg       in         cfg_we_i cfg_idx_i cfg_data_i register write, no read-back
//
// Every item produces exactly one result item. A set speed, stop, tick or a soft
// start that needs no ramp then runs these steps in order: one forms
// duty * (reload + 1), one divides that by one hundred with a reciprocal multiply,
// and one loads the result. A soft start that begins a ramp first runs the
// one-bit-per-cycle divider for the step delay. s_axis_tready is high only
// while the sequencer is idle, so a new item is taken only once the last result
// is loaded. A finished result waits in the output register while the next item
// is accepted; a stall there holds the final load and so also new items. Reset
// is asynchronous and restores configuration, control state and output valid;
// the datapath and output data registers are not reset. No clearing pass is needed.
module pwm_duty_soft_start_ramp #(
  parameter int unsigned RELOAD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] speed request
  input  logic [1:0]                           s_axis_tuser,  // [1:0] action
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] status, [8:2] duty, [25:9] compare, [26] ramp_active, rest zero
  output logic [pdsr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [pdsr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pdsr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import pdsr_pkg::*;

  // The reload register keeps only the low RELOAD_WIDTH bits (at most 16) of the write data.
  localparam int unsigned EW   = (RELOAD_WIDTH < 16) ? RELOAD_WIDTH : 16;
  localparam int unsigned PW   = EW + 1;              // period = reload + 1
  localparam int unsigned DW   = PW + DUTY_W;         // duty * period
  localparam int unsigned RP_W = CMP_SHIFT + CMP_W;   // reciprocal product

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_STEP = 5'b00010,
    S_MUL  = 5'b00100,
    S_CMP  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic              enabled_q;
  logic [DUTY_W-1:0] max_duty_q, deadband_q;
  logic [MS_W-1:0]   ramp_total_q;
  logic [EW-1:0]     reload_q;

  // Controller state.
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic [DUTY_W-1:0] target_q, target_d;
  logic [MS_W-1:0]   step_delay_q, step_delay_d;
  logic [MS_W-1:0]   tick_q, tick_d;
  logic              ramp_on_q, ramp_on_d;
  logic [1:0]        status_q, status_d;

  // Output register.
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Datapath.
  action_e           action;
  logic [SPEED_W-1:0] speed;
  logic [DUTY_W-1:0] limit, steps, duty_inc;
  logic [MS_W-1:0]   tick_inc;
  logic              accept, start_ramp, out_free;
  logic [PW-1:0]     period;
  logic [DW-1:0]     product, prod_q;
  logic [RP_W-1:0]   recip_prod;
  logic [CMP_W-1:0]  cmp_q;
  logic [MS_W-1:0]   div_dividend, div_quot;
  logic [DUTY_W-1:0] div_divisor;
  logic              div_start;
  div_stat_t         div_stat;
  logic [MS_W-1:0]   step_quot;

  assign action   = action_e'(s_axis_tuser);
  assign speed    = s_axis_tdata;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  assign limit    = (max_duty_q > PCT_FULL) ? PCT_FULL : max_duty_q;
  assign steps    = speed[DUTY_W-1:0] - duty_q;
  assign duty_inc = duty_q + DUTY_W'(1);
  assign tick_inc = tick_q + MS_W'(1);

  assign period  = {1'b0, reload_q} + PW'(1);
  assign product = DW'(duty_q) * DW'(period);

  // The registered product is divided by one hundred in the following cycle.
  assign recip_prod = RP_W'(prod_q) * RP_W'(CMP_RECIP);

  // Command decode. Any command other than a tick cancels a running ramp.
  always_comb begin
    duty_d     = duty_q;
    target_d   = target_q;
    tick_d     = tick_q;
    ramp_on_d  = ramp_on_q;
    status_d   = status_q;
    start_ramp = 1'b0;
    if (accept) begin
      status_d = ST_OK;
      if (action != ACT_TICK) begin
        ramp_on_d = 1'b0;
      end
      case (action)
        ACT_SET_SPEED: begin
          if (!enabled_q) begin
            status_d = ST_NOT_READY;
          end else if (speed > {1'b0, limit}) begin
            status_d = ST_INVALID;
          end else if (speed < {1'b0, deadband_q}) begin
            duty_d = '0;
          end else begin
            duty_d = speed[DUTY_W-1:0];
          end
        end
        ACT_STOP: begin
          duty_d = '0;
        end
        ACT_SOFT_START: begin
          if (!enabled_q) begin
            status_d = ST_NOT_READY;
          end else if (speed > {1'b0, limit}) begin
            status_d = ST_INVALID;
          end else if ({1'b0, duty_q} >= speed) begin
            duty_d = speed[DUTY_W-1:0];
          end else begin
            // First step is taken at once; the step delay comes from the divider.
            start_ramp = 1'b1;
            target_d   = speed[DUTY_W-1:0];
            tick_d     = '0;
            duty_d     = duty_inc;
            ramp_on_d  = (duty_inc < speed[DUTY_W-1:0]);
          end
        end
        ACT_TICK: begin
          if (ramp_on_q) begin
            if (tick_inc >= step_delay_q) begin
              tick_d = '0;
              if (duty_q < target_q) begin
                duty_d = duty_inc;
                ramp_on_d = (duty_inc < target_q);
              end else begin
                ramp_on_d = 1'b0;
              end
            end else begin
              tick_d = tick_inc;
            end
          end
        end
        default: begin
          duty_d = duty_q;
        end
      endcase
    end
  end

  // The divider forms the step delay when a ramp starts.
  assign div_start    = start_ramp;
  assign div_dividend = ramp_total_q;
  assign div_divisor  = steps;
  assign step_quot    = div_quot;

  always_comb begin
    step_delay_d = step_delay_q;
    if ((state_q == S_STEP) && div_stat.done) begin
      step_delay_d = (step_quot == '0) ? MS_W'(1) : step_quot;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = start_ramp ? S_STEP : S_MUL;
        end
      end
      S_STEP: begin
        if (div_stat.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  pdsr_div #(
    .DIVIDEND_W (MS_W),
    .DIVISOR_W  (DUTY_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b0;
      max_duty_q   <= PCT_FULL;
      deadband_q   <= '0;
      ramp_total_q <= MS_W'(500);
      reload_q     <= EW'(999);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOTOR_ENABLED: enabled_q    <= cfg_data_i[0];
        REG_MAX_DUTY:      max_duty_q   <= cfg_data_i[DUTY_W-1:0];
        REG_DEADBAND:      deadband_q   <= cfg_data_i[DUTY_W-1:0];
        REG_RAMP_TOTAL:    ramp_total_q <= cfg_data_i[MS_W-1:0];
        REG_PERIOD_RELOAD: reload_q     <= cfg_data_i[EW-1:0];
        default: begin
          enabled_q <= enabled_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      duty_q       <= '0;
      target_q     <= '0;
      step_delay_q <= MS_W'(1);
      tick_q       <= '0;
      ramp_on_q    <= 1'b0;
      status_q     <= ST_OK;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      duty_q       <= duty_d;
      target_q     <= target_d;
      step_delay_q <= step_delay_d;
      tick_q       <= tick_d;
      ramp_on_q    <= ramp_on_d;
      status_q     <= status_d;
      if ((state_q == S_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_q <= product;
    end
    if (state_q == S_CMP) begin
      cmp_q <= recip_prod[RP_W-1:CMP_SHIFT];
    end
    if ((state_q == S_DONE) && out_free) begin
      m_data_q <= {{(OUT_DATA_W - 2 - DUTY_W - CMP_W - 1){1'b0}},
                   ramp_on_q, cmp_q, duty_q, status_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The applied duty never passes full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni) duty_q <= PCT_FULL)
    else $error("duty above full scale");

  // A running ramp always has room left to its target.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ramp_on_q |-> (duty_q < target_q))
    else $error("ramp active at or past its target");

  // The step delay is held at one tick or more.
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_delay_q != '0)
    else $error("zero step delay");

  // The divider is never restarted while it is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // Once the step delay is ready the compare path runs next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_STEP) && div_stat.done |=> (state_q == S_MUL))
    else $error("step division finished without entering the multiply state");

endmodule
